// File: hdl/mdpd_pkg.sv
// Shared types and constants for the median defect pixel detector.
// Depends on nothing; used by the top level and its testbench.
`timescale 1ns / 1ps

package mdpd_pkg;

  // Transaction opcodes; the last one is unused and does nothing.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TEST  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_BAYER     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;
  localparam logic [1:0] CFG_WIDTH     = 2'd3;

  // Window geometry: side length, half side and tap count.
  localparam logic [2:0] DIM_SMALL      = 3'd3;
  localparam logic [2:0] DIM_MONO_BIG   = 3'd7;
  localparam logic [2:0] DIM_BAYER_BIG  = 3'd5;
  localparam logic [1:0] HALF_SMALL     = 2'd1;
  localparam logic [1:0] HALF_MONO_BIG  = 2'd3;
  localparam logic [1:0] HALF_BAYER_BIG = 2'd2;
  localparam logic [5:0] TAPS_SMALL     = 6'd9;
  localparam logic [5:0] TAPS_MONO_BIG  = 6'd49;
  localparam logic [5:0] TAPS_BAYER_BIG = 6'd25;
  localparam int         WIN_DEPTH      = 49;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [15:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic defect_now;
    logic defect_sticky;
  } out_item_t;

endpackage

// File: hdl/mdpd_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mdpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/median_defect_pixel_detector.sv
// Top level of the median defect pixel detector; uses mdpd_pkg and mdpd_ram.
// Load, clear and the unused opcode leave busy low; a test outside the frame
// answers on the next cycle. A test in the frame keeps busy high through its steps
// (n = 9, 25 or 49 taps): gather, pixel latch, rank select, compare and map update;
// the result strobes in the cycle after the map update. After reset busy stays high
// while the map is swept.
`timescale 1ns / 1ps

module median_defect_pixel_detector #(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int PIXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mdpd_pkg::in_item_t in_item,
  output logic               out_valid,
  output mdpd_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int SRW   = HW + 2;
  localparam int SCW   = WW + 2;
  localparam int BIW   = $clog2(PIXEL_BITS);
  localparam int WAW   = $clog2(mdpd_pkg::WIN_DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_GATHER = 7'b0000100,
    ST_CURW   = 7'b0001000,
    ST_SELECT = 7'b0010000,
    ST_DIFF   = 7'b0100000,
    ST_MAPWR  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] thr_r;
  logic        bayer_r;
  logic [7:0]  fh_r, fw_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 16'd256;
      bayer_r <= 1'b0;
      fh_r    <= 8'd128;
      fw_r    <= 8'd128;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mdpd_pkg::CFG_THRESHOLD: thr_r   <= cfg_data;
        mdpd_pkg::CFG_BAYER:     bayer_r <= cfg_data[0];
        mdpd_pkg::CFG_HEIGHT:    fh_r    <= cfg_data[7:0];
        mdpd_pkg::CFG_WIDTH:     fw_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: saturated, and even in mosaic mode.
  logic [HW-1:0] eff_h;
  logic [WW-1:0] eff_w;

  always_comb begin
    if (32'(fh_r) > MAX_ROWS) begin
      eff_h = HW'(MAX_ROWS);
    end else if (fh_r < 8'd8) begin
      eff_h = HW'(8);
    end else begin
      eff_h = HW'(fh_r);
    end
    if (32'(fw_r) > MAX_COLS) begin
      eff_w = WW'(MAX_COLS);
    end else if (fw_r < 8'd8) begin
      eff_w = WW'(8);
    end else begin
      eff_w = WW'(fw_r);
    end
    if (bayer_r) begin
      eff_h[0] = 1'b0;
      eff_w[0] = 1'b0;
    end
  end

  // Accept decode and window choice for a new transaction.
  logic        acc;
  logic [31:0] r32, c32, h32, w32;
  logic        in_store, in_frame, edge_win;
  logic [RB-1:0] row_w;
  logic [CB-1:0] col_w;
  logic [AW-1:0] in_addr;

  assign busy = (state_r != ST_IDLE);
  assign acc  = start && !busy;

  always_comb begin
    r32      = 32'(in_item.row);
    c32      = 32'(in_item.col);
    h32      = 32'(eff_h);
    w32      = 32'(eff_w);
    in_store = (r32 < MAX_ROWS) && (c32 < MAX_COLS);
    in_frame = (r32 < h32) && (c32 < w32);
    if (!bayer_r) begin
      edge_win = (r32 < 3) || (r32 + 3 >= h32) || (c32 < 3) || (c32 + 3 >= w32);
    end else begin
      edge_win = ((r32 & ~32'd1) < 4) || ((r32 & ~32'd1) + 4 >= h32) ||
                 ((c32 & ~32'd1) < 4) || ((c32 & ~32'd1) + 4 >= w32);
    end
    row_w   = RB'(in_item.row);
    col_w   = CB'(in_item.col);
    in_addr = AW'(AW'(row_w) * AW'(MAX_COLS)) + AW'(col_w);
  end

  // Transaction registers.
  logic [RB-1:0]  row_r;
  logic [CB-1:0]  col_r;
  logic [AW-1:0]  addr_r;
  logic           small_r;
  logic [2:0]     dim_r;
  logic [1:0]     half_r;
  logic [5:0]     n_r;

  // Gather counters.
  logic [2:0]     tm_r, tk_r;
  logic [5:0]     g_r;
  logic           pend_r;
  logic [WAW-1:0] widx_r;

  // Select unit state.
  logic [PIXEL_BITS-1:0] cur_r, prefix_r;
  logic [BIW-1:0]        bit_r;
  logic [5:0]            k_r, cnt_r, j_r;
  logic                  rv_r;
  logic                  now_r;

  // Clearing sweep.
  logic [AW-1:0] clr_r;

  // Output register.
  logic      out_valid_r;
  mdpd_pkg::out_item_t out_item_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Memory ports.
  logic                  frame_we;
  logic [AW-1:0]         frame_raddr;
  logic [PIXEL_BITS-1:0] frame_rdata;
  logic                  map_we, map_wdata, map_rdata;
  logic [AW-1:0]         map_waddr;
  logic [PIXEL_BITS-1:0] win_rdata;

  // Tap coordinate for the current gather step.
  logic signed [4:0]     off_m, off_k;
  logic signed [SRW-1:0] ty, hs;
  logic signed [SCW-1:0] tx, ws;
  logic [AW-1:0]         tap_addr;

  always_comb begin
    hs    = $signed(SRW'(eff_h));
    ws    = $signed(SCW'(eff_w));
    off_m = (5'(tm_r) - 5'(half_r)) <<< (bayer_r ? 1 : 0);
    off_k = (5'(tk_r) - 5'(half_r)) <<< (bayer_r ? 1 : 0);
    ty    = $signed(SRW'(row_r)) + SRW'(off_m);
    tx    = $signed(SCW'(col_r)) + SCW'(off_k);
    if (small_r) begin
      if (ty < 0) ty = ty + (bayer_r ? SRW'(4) : SRW'(2));
      if (ty > hs - 1) ty = ty - (bayer_r ? SRW'(4) : SRW'(2));
      if (tx < 0) tx = tx + (bayer_r ? SCW'(4) : SCW'(2));
      if (tx > ws - 1) tx = tx - (bayer_r ? SCW'(4) : SCW'(2));
    end else if (!bayer_r) begin
      if (ty < 0) ty = '0;
      if (ty > hs - 1) ty = hs - SRW'(1);
      if (tx < 0) tx = '0;
      if (tx > ws - 1) tx = ws - SCW'(1);
    end else begin
      if (ty < $signed(SRW'(row_r[0]))) ty = $signed(SRW'(row_r[0]));
      if (ty > hs - 2 + $signed(SRW'(row_r[0]))) ty = hs - SRW'(2) + $signed(SRW'(row_r[0]));
      if (tx < $signed(SCW'(col_r[0]))) tx = $signed(SCW'(col_r[0]));
      if (tx > ws - 2 + $signed(SCW'(col_r[0]))) tx = ws - SCW'(2) + $signed(SCW'(col_r[0]));
    end
    tap_addr = AW'(AW'(ty[RB-1:0]) * AW'(MAX_COLS)) + AW'(tx[CB-1:0]);
  end

  // Rank count compare: value matches the prefix above the current bit and
  // has a zero in the current bit.
  logic [PIXEL_BITS-1:0] mask_ge;
  logic                  match;
  logic [5:0]            cnt_fin;

  always_comb begin
    mask_ge = {PIXEL_BITS{1'b1}} << bit_r;
    match   = rv_r && ((win_rdata & mask_ge) == (prefix_r & mask_ge));
    cnt_fin = cnt_r + 6'(match);
  end

  // Absolute deviation and threshold compare.
  logic [PIXEL_BITS-1:0] diff;

  assign diff = (cur_r >= prefix_r) ? (cur_r - prefix_r) : (prefix_r - cur_r);

  // Memory write and read selection.
  assign frame_we    = acc && (in_item.opcode == mdpd_pkg::OP_LOAD) && in_store;
  assign frame_raddr = (g_r < n_r) ? tap_addr : addr_r;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = addr_r;
    map_wdata = 1'b0;
    if (state_r == ST_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_r;
    end else if (state_r == ST_MAPWR) begin
      map_we    = now_r;
      map_wdata = 1'b1;
    end else if (acc && (in_item.opcode == mdpd_pkg::OP_CLEAR) && in_store) begin
      map_we    = 1'b1;
      map_waddr = in_addr;
    end
  end

  mdpd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (in_addr),
    .wdata (in_item.pixel_value[PIXEL_BITS-1:0]),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  mdpd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (addr_r),
    .rdata (map_rdata)
  );

  mdpd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(mdpd_pkg::WIN_DEPTH)) u_win (
    .clk   (clk),
    .we    (pend_r),
    .waddr (widx_r),
    .wdata (frame_rdata),
    .raddr (j_r[WAW-1:0]),
    .rdata (win_rdata)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (in_item.opcode == mdpd_pkg::OP_TEST) && in_frame) begin
          state_nxt = ST_GATHER;
        end
      end
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_GATHER: begin
        if (g_r == n_r) state_nxt = ST_CURW;
      end
      ST_CURW:   state_nxt = ST_SELECT;
      ST_SELECT: begin
        if ((j_r == n_r) && (bit_r == '0)) state_nxt = ST_DIFF;
      end
      ST_DIFF:   state_nxt = ST_MAPWR;
      ST_MAPWR:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      rv_r        <= 1'b0;
      g_r         <= '0;
      j_r         <= '0;
      n_r         <= mdpd_pkg::TAPS_SMALL;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_IDLE: begin
          if (acc && (in_item.opcode == mdpd_pkg::OP_TEST)) begin
            if (!in_frame) begin
              out_valid_r <= 1'b1;
            end
            g_r <= '0;
            if (edge_win) begin
              n_r <= mdpd_pkg::TAPS_SMALL;
            end else if (bayer_r) begin
              n_r <= mdpd_pkg::TAPS_BAYER_BIG;
            end else begin
              n_r <= mdpd_pkg::TAPS_MONO_BIG;
            end
          end
        end
        ST_GATHER: begin
          pend_r <= (g_r < n_r);
          if (g_r < n_r) g_r <= g_r + 6'd1;
        end
        ST_CURW: begin
          pend_r <= 1'b0;
          j_r    <= '0;
          rv_r   <= 1'b0;
        end
        ST_SELECT: begin
          if (j_r < n_r) begin
            j_r  <= j_r + 6'd1;
            rv_r <= 1'b1;
          end else begin
            j_r  <= '0;
            rv_r <= 1'b0;
          end
        end
        ST_MAPWR: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        row_r   <= row_w;
        col_r   <= col_w;
        addr_r  <= in_addr;
        small_r <= edge_win;
        tm_r    <= '0;
        tk_r    <= '0;
        if (edge_win) begin
          dim_r  <= mdpd_pkg::DIM_SMALL;
          half_r <= mdpd_pkg::HALF_SMALL;
        end else if (bayer_r) begin
          dim_r  <= mdpd_pkg::DIM_BAYER_BIG;
          half_r <= mdpd_pkg::HALF_BAYER_BIG;
        end else begin
          dim_r  <= mdpd_pkg::DIM_MONO_BIG;
          half_r <= mdpd_pkg::HALF_MONO_BIG;
        end
        out_item_r <= '0;
      end
      ST_GATHER: begin
        widx_r <= WAW'(g_r);
        if (tk_r == dim_r - 3'd1) begin
          tk_r <= '0;
          tm_r <= tm_r + 3'd1;
        end else begin
          tk_r <= tk_r + 3'd1;
        end
      end
      ST_CURW: begin
        cur_r    <= frame_rdata;
        prefix_r <= '0;
        bit_r    <= BIW'(PIXEL_BITS - 1);
        k_r      <= n_r >> 1;
        cnt_r    <= '0;
      end
      ST_SELECT: begin
        if (j_r == n_r) begin
          cnt_r <= '0;
          if (k_r >= cnt_fin) begin
            prefix_r[bit_r] <= 1'b1;
            k_r             <= k_r - cnt_fin;
          end
          if (bit_r != '0) bit_r <= bit_r - BIW'(1);
        end else begin
          cnt_r <= cnt_fin;
        end
      end
      ST_DIFF: now_r <= (16'(diff) >= thr_r);
      ST_MAPWR: begin
        out_item_r.defect_now    <= now_r;
        out_item_r.defect_sticky <= map_rdata | now_r;
      end
      default: ;
    endcase
  end

  // A result follows either a map update or a test outside the frame.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_MAPWR) || $past(acc))
    else $error("result strobe without a finished test");

  // The target rank always stays inside the window during selection.
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SELECT) |-> (k_r < n_r) && (cnt_r <= n_r))
    else $error("median rank or count out of window range");

  // The gather never issues more taps than the window holds.
  a_gather_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER) |-> (g_r <= n_r))
    else $error("gather ran past the window");

  // No result appears while the map sweep runs, since no transaction is taken then.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid)
    else $error("result during map clearing sweep");

endmodule

// File: test/tb_median_defect_pixel_detector.sv
// Self-checking testbench for the median defect pixel detector.
// Depends on mdpd_pkg and median_defect_pixel_detector; the scoreboard class
// keeps its own frame, defect map and register copies to predict each result.
`timescale 1ns / 1ps

module tb_median_defect_pixel_detector;

  localparam int ROWS = 128;
  localparam int COLS = 128;
  localparam int STALL_LIMIT = 100000;

  // Predicts test results and compares them with what the block returns.
  class defect_scoreboard;
    logic [15:0]   pixels [ROWS*COLS];
    bit            written [ROWS*COLS];
    bit            defect_map [ROWS*COLS];
    int            threshold = 256;
    bit            bayer = 0;
    int            height_reg = 128;
    int            width_reg = 128;
    mdpd_pkg::out_item_t expected [$];
    int            errors = 0;
    int            win_y [$];
    int            win_x [$];

    function int eff_size(int v, int max_v);
      if (v < 8) v = 8;
      if (v > max_v) v = max_v;
      if (bayer) v = v & ~1;
      return v;
    endfunction

    function int eff_height();
      return eff_size(height_reg, ROWS);
    endfunction

    function int eff_width();
      return eff_size(width_reg, COLS);
    endfunction

    function int mirror(int v, int lim, int step);
      if (v < 0) v += step;
      if (v > lim - 1) v -= step;
      return v;
    endfunction

    function int clip(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Builds the tap coordinates of the window around an in-frame pixel.
    function void build_window(int r, int c);
      int h;
      int w;
      int pr;
      int pc;
      int qr;
      int qc;
      h = eff_height();
      w = eff_width();
      win_y.delete();
      win_x.delete();
      if (!bayer) begin
        if (r < 3 || r >= h - 3 || c < 3 || c >= w - 3) begin
          for (int m = -1; m <= 1; m++)
            for (int k = -1; k <= 1; k++) begin
              win_y.push_back(mirror(r + m, h, 2));
              win_x.push_back(mirror(c + k, w, 2));
            end
        end else begin
          for (int m = -3; m <= 3; m++)
            for (int k = -3; k <= 3; k++) begin
              win_y.push_back(clip(r + m, 0, h - 1));
              win_x.push_back(clip(c + k, 0, w - 1));
            end
        end
      end else begin
        qr = r & ~1;
        qc = c & ~1;
        pr = r & 1;
        pc = c & 1;
        if (qr < 4 || qr >= h - 4 || qc < 4 || qc >= w - 4) begin
          for (int m = -2; m <= 2; m += 2)
            for (int k = -2; k <= 2; k += 2) begin
              win_y.push_back(mirror(r + m, h, 4));
              win_x.push_back(mirror(c + k, w, 4));
            end
        end else begin
          for (int m = -4; m <= 4; m += 2)
            for (int k = -4; k <= 4; k += 2) begin
              win_y.push_back(clip(r + m, pr, h - 2 + pr));
              win_x.push_back(clip(c + k, pc, w - 2 + pc));
            end
        end
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        mdpd_pkg::CFG_THRESHOLD: threshold = data;
        mdpd_pkg::CFG_BAYER:     bayer = data[0];
        mdpd_pkg::CFG_HEIGHT:    height_reg = data[7:0];
        mdpd_pkg::CFG_WIDTH:     width_reg = data[7:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted input transaction and queues any expected result.
    function void note_input(mdpd_pkg::in_item_t it);
      int addr;
      int vals [$];
      int med;
      int cur;
      int diff;
      mdpd_pkg::out_item_t res;
      addr = it.row * COLS + it.col;
      case (it.opcode)
        mdpd_pkg::OP_LOAD: begin
          pixels[addr] = it.pixel_value;
          written[addr] = 1'b1;
        end
        mdpd_pkg::OP_CLEAR: defect_map[addr] = 1'b0;
        mdpd_pkg::OP_TEST: begin
          res = '0;
          if (it.row < eff_height() && it.col < eff_width()) begin
            build_window(it.row, it.col);
            foreach (win_y[i]) vals.push_back(pixels[win_y[i] * COLS + win_x[i]]);
            vals.sort();
            med = vals[vals.size() / 2];
            cur = pixels[addr];
            diff = (cur >= med) ? cur - med : med - cur;
            res.defect_now = (diff >= threshold);
            if (res.defect_now) defect_map[addr] = 1'b1;
            res.defect_sticky = defect_map[addr];
          end
          expected.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(mdpd_pkg::out_item_t got);
      mdpd_pkg::out_item_t exp_item;
      if (expected.size() == 0) begin
        $display("%0t: result expected none actual %b", $time, got);
        errors++;
        return;
      end
      exp_item = expected.pop_front();
      if (got.defect_now !== exp_item.defect_now) begin
        $display("%0t: defect_now expected %b actual %b", $time,
                 exp_item.defect_now, got.defect_now);
        errors++;
      end
      if (got.defect_sticky !== exp_item.defect_sticky) begin
        $display("%0t: defect_sticky expected %b actual %b", $time,
                 exp_item.defect_sticky, got.defect_sticky);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  mdpd_pkg::in_item_t  in_item = '0;
  logic        out_valid;
  mdpd_pkg::out_item_t out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = mdpd_pkg::CFG_THRESHOLD;
  logic [15:0] cfg_data = '0;

  defect_scoreboard sb = new();
  int item_count = 0;
  int stall_cycles = 0;

  always #1 clk = ~clk;

  median_defect_pixel_detector uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Result monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Watchdog: ends the run after a long stretch with no transaction at all.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drives one transaction and waits until the block takes it.
  task automatic send(logic [1:0] op, int r, int c, int value);
    mdpd_pkg::in_item_t it;
    int gap;
    it.opcode = op;
    it.row = 7'(r);
    it.col = 7'(c);
    it.pixel_value = 16'(value);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(it);
    item_count++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits for outstanding results, then for a load or clear to finish.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers back to back.
  task automatic configure(int thr, int bay, int h, int w);
    logic [15:0] vals [4];
    vals[0] = 16'(thr);
    vals[1] = 16'(bay);
    vals[2] = 16'(h);
    vals[3] = 16'(w);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Tests a pixel, first loading any window tap never written.
  task automatic test_pixel(int r, int c, int base);
    int ys [$];
    int xs [$];
    if (r < sb.eff_height() && c < sb.eff_width()) begin
      sb.build_window(r, c);
      ys = sb.win_y;
      xs = sb.win_x;
      foreach (ys[i])
        if (!sb.written[ys[i] * COLS + xs[i]])
          send(mdpd_pkg::OP_LOAD, ys[i], xs[i], base + $urandom_range(0, 200));
    end
    send(mdpd_pkg::OP_TEST, r, c, $urandom);
  endtask

  // Fills the frame in use with a smooth surface and a few hot or dead spikes.
  task automatic fill_frame(int base);
    for (int r = 0; r < sb.eff_height(); r++)
      for (int c = 0; c < sb.eff_width(); c++)
        send(mdpd_pkg::OP_LOAD, r, c, ($urandom_range(0, 19) == 0) ? $urandom
                                                          : base + $urandom_range(0, 300));
  endtask

  function int pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2: return $urandom;
      default: return $urandom_range(20, 600);
    endcase
  endfunction

  function int pick_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 255);
      1: return $urandom_range(0, 7);
      default: return $urandom_range(8, 14);
    endcase
  endfunction

  initial begin
    int base;
    int op_pick;
    int h;
    int w;
    int tests;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner reflection, zero threshold, out-of-frame test,
    // unused opcode, clear, and loads outside the frame in use.
    configure(0, 0, 8, 8);
    test_pixel(0, 0, 1000);
    test_pixel(7, 7, 1000);
    send(mdpd_pkg::OP_TEST, 127, 127, 16'hFFFF);
    send(mdpd_pkg::OP_LOAD, 127, 127, 16'hFFFF);
    send(mdpd_pkg::OP_NONE, 127, 127, 16'hFFFF);
    send(mdpd_pkg::OP_CLEAR, 0, 0, 16'h0000);
    test_pixel(0, 0, 1000);
    wait_idle();
    configure(65535, 1, 9, 9);
    test_pixel(1, 1, 0);
    test_pixel(7, 6, 0);
    send(mdpd_pkg::OP_TEST, 8, 3, 16'h0000);
    wait_idle();
    configure(16, 0, 255, 255);
    test_pixel(127, 127, 40000);
    test_pixel(64, 64, 40000);
    wait_idle();

    // Random phases: new settings, a filled frame, then a mix of operations.
    while (item_count < 1100) begin
      configure(pick_threshold(), $urandom_range(0, 1), pick_size(), pick_size());
      h = sb.eff_height();
      w = sb.eff_width();
      base = $urandom_range(0, 65000);
      if (h * w <= 256) fill_frame(base);
      tests = (h * w <= 256) ? 30 : 6;
      for (int i = 0; i < tests; i++) begin
        op_pick = $urandom_range(0, 99);
        if (op_pick < 60)
          test_pixel($urandom_range(0, h - 1), $urandom_range(0, w - 1), base);
        else if (op_pick < 75)
          send(mdpd_pkg::OP_LOAD, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
               ($urandom_range(0, 1) != 0) ? $urandom : base + $urandom_range(0, 300));
        else if (op_pick < 85)
          send(mdpd_pkg::OP_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
        else if (op_pick < 92 && h < ROWS)
          send(mdpd_pkg::OP_TEST, $urandom_range(h, 127), $urandom_range(0, 127), $urandom);
        else if (op_pick < 96)
          send(mdpd_pkg::OP_LOAD, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
        else
          send(mdpd_pkg::OP_NONE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
